// ===== rtl/core/acull_pkg.sv =====
package acull_pkg;

  localparam int WORD_W      = 64;
  localparam int ROW_COUNT   = 3;
  localparam int VP_ROWS     = 4;
  localparam int LANES       = 4;
  localparam int PLANES      = 6;
  localparam int COEF_FRAC   = 12;
  localparam int COORD_FRAC  = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ROW_NONE = 2'd3;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_TEST = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    CFG_VP_ROW0 = 2'd0,
    CFG_VP_ROW1 = 2'd1,
    CFG_VP_ROW2 = 2'd2,
    CFG_VP_ROW3 = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } q_status_t;

endpackage

// ===== rtl/core/acull_front.sv =====
module acull_front import acull_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       func,
  input  logic [1:0]                 row_index,
  input  logic [WORD_W-1:0]          row_word,
  input  logic [COORD_WIDTH-1:0]     box_min_x,
  input  logic [COORD_WIDTH-1:0]     box_min_y,
  input  logic [COORD_WIDTH-1:0]     box_min_z,
  input  logic [COORD_WIDTH-1:0]     box_max_x,
  input  logic [COORD_WIDTH-1:0]     box_max_y,
  input  logic [COORD_WIDTH-1:0]     box_max_z,
  input  q_status_t                  q_status,
  output logic                       push,
  output logic [6*COORD_WIDTH-1:0]   push_data
);

  localparam int PW = COEF_WIDTH + COORD_WIDTH;
  localparam int TW = COEF_WIDTH + COORD_FRAC;
  localparam int SW = PW + 3;
  localparam int CEIL_ADD = (1 << COEF_FRAC) - 1;
  localparam logic signed [SW-1:0] CMAX = {{(SW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [SW-1:0] CMIN = {{(SW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic [WORD_W-1:0]               world_matrix [ROW_COUNT];
  logic signed [COEF_WIDTH-1:0]    wm [ROW_COUNT][LANES];
  logic signed [COORD_WIDTH-1:0]   box_a [3];
  logic signed [COORD_WIDTH-1:0]   box_b [3];
  logic signed [COORD_WIDTH-1:0]   bmin [3];
  logic signed [COORD_WIDTH-1:0]   bmax [3];
  logic signed [PW-1:0]            p_lo_next [3][3];
  logic signed [PW-1:0]            p_hi_next [3][3];
  logic signed [TW-1:0]            t_next [3];
  logic signed [PW-1:0]            p_lo [3][3];
  logic signed [PW-1:0]            p_hi [3][3];
  logic signed [TW-1:0]            t [3];
  logic                            f1_valid;
  logic                            accept;
  logic signed [SW-1:0]            s_lo;
  logic signed [SW-1:0]            s_hi;

  function automatic logic signed [COEF_WIDTH-1:0] lane_of(input logic [WORD_W-1:0] w,
                                                           input int c);
    logic [WORD_W+LANES*COEF_WIDTH-1:0] ext;
    ext = {{(LANES*COEF_WIDTH){1'b0}}, w};
    return ext[c*COEF_WIDTH +: COEF_WIDTH];
  endfunction

  function automatic logic [COORD_WIDTH-1:0] sat(input logic signed [SW-1:0] v);
    if (v > CMAX) begin
      return CMAX[COORD_WIDTH-1:0];
    end else if (v < CMIN) begin
      return CMIN[COORD_WIDTH-1:0];
    end
    return v[COORD_WIDTH-1:0];
  endfunction

  assign accept = in_valid && !in_stall;
  assign in_stall = ((QCNT_W+1)'(q_status.count) + (QCNT_W+1)'(f1_valid))
                    >= (QCNT_W+1)'(QUEUE_DEPTH);

  always_comb begin
    box_a[0] = box_min_x; box_a[1] = box_min_y; box_a[2] = box_min_z;
    box_b[0] = box_max_x; box_b[1] = box_max_y; box_b[2] = box_max_z;
    for (int j = 0; j < 3; j++) begin
      bmin[j] = (box_a[j] < box_b[j]) ? box_a[j] : box_b[j];
      bmax[j] = (box_a[j] < box_b[j]) ? box_b[j] : box_a[j];
    end
    for (int i = 0; i < ROW_COUNT; i++) begin
      for (int j = 0; j < LANES; j++) begin
        wm[i][j] = lane_of(world_matrix[i], j);
      end
      for (int j = 0; j < 3; j++) begin
        p_lo_next[i][j] = PW'(wm[i][j]) *
          PW'(wm[i][j][COEF_WIDTH-1] ? bmax[j] : bmin[j]);
        p_hi_next[i][j] = PW'(wm[i][j]) *
          PW'(wm[i][j][COEF_WIDTH-1] ? bmin[j] : bmax[j]);
      end
      t_next[i] = $signed({wm[i][3], {COORD_FRAC{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      for (int i = 0; i < ROW_COUNT; i++) begin
        world_matrix[i] <= '0;
      end
    end else begin
      f1_valid <= accept && (func_t'(func) == FUNC_TEST);
      if (accept && (func_t'(func) == FUNC_LOAD) && (row_index != ROW_NONE)) begin
        world_matrix[row_index] <= row_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_lo <= p_lo_next;
      p_hi <= p_hi_next;
      t    <= t_next;
    end
  end

  assign push = f1_valid;

  always_comb begin
    push_data = '0;
    for (int i = 0; i < ROW_COUNT; i++) begin
      s_lo = SW'(p_lo[i][0]) + SW'(p_lo[i][1]) + SW'(p_lo[i][2]) + SW'(t[i]);
      s_hi = SW'(p_hi[i][0]) + SW'(p_hi[i][1]) + SW'(p_hi[i][2]) + SW'(t[i])
             + SW'(CEIL_ADD);
      push_data[i*COORD_WIDTH +: COORD_WIDTH]     = sat(s_lo >>> COEF_FRAC);
      push_data[(i+3)*COORD_WIDTH +: COORD_WIDTH] = sat(s_hi >>> COEF_FRAC);
    end
  end

endmodule

// ===== rtl/core/acull_queue.sv =====
module acull_queue import acull_pkg::*; #(
  parameter int DATA_W = 96
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data,
  output q_status_t         q_status
);

  logic [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign pop_valid = (count != '0);
  assign do_pop    = pop && pop_valid;
  assign pop_data  = mem[rd_ptr];
  assign q_status.count = count;
  assign q_status.full  = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/acull_back.sv =====
module acull_back import acull_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [WORD_W-1:0]        vp_row [VP_ROWS],
  input  logic                     pop_valid,
  input  logic [6*COORD_WIDTH-1:0] pop_data,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     visible,
  output logic [COORD_WIDTH-1:0]   world_min_x,
  output logic [COORD_WIDTH-1:0]   world_min_y,
  output logic [COORD_WIDTH-1:0]   world_min_z,
  output logic [COORD_WIDTH-1:0]   world_max_x,
  output logic [COORD_WIDTH-1:0]   world_max_y,
  output logic [COORD_WIDTH-1:0]   world_max_z
);

  localparam int PCW = COEF_WIDTH + 1;
  localparam int PPW = PCW + COORD_WIDTH;
  localparam int CTW = PCW + COORD_FRAC;
  localparam int DW  = PPW + 3;

  logic signed [COEF_WIDTH-1:0]  r [VP_ROWS][LANES];
  logic signed [PCW-1:0]         pl_next [PLANES][LANES];
  logic signed [PCW-1:0]         pl [PLANES][LANES];
  logic signed [COORD_WIDTH-1:0] wmin [3];
  logic signed [COORD_WIDTH-1:0] wmax [3];
  logic signed [PPW-1:0]         prod_next [PLANES][3];
  logic signed [PPW-1:0]         prod [PLANES][3];
  logic signed [CTW-1:0]         ct [PLANES];
  logic [6*COORD_WIDTH-1:0]      b1_box;
  logic                          b1_valid;
  logic                          en;
  logic                          all_pass;
  logic signed [DW-1:0]          d;

  function automatic logic signed [COEF_WIDTH-1:0] lane_of(input logic [WORD_W-1:0] w,
                                                           input int c);
    logic [WORD_W+LANES*COEF_WIDTH-1:0] ext;
    ext = {{(LANES*COEF_WIDTH){1'b0}}, w};
    return ext[c*COEF_WIDTH +: COEF_WIDTH];
  endfunction

  assign en  = !out_valid || !out_stall;
  assign pop = en;

  always_comb begin
    for (int i = 0; i < VP_ROWS; i++) begin
      for (int j = 0; j < LANES; j++) begin
        r[i][j] = lane_of(vp_row[i], j);
      end
    end
    for (int j = 0; j < LANES; j++) begin
      pl_next[0][j] = PCW'(r[3][j]) + PCW'(r[0][j]);
      pl_next[1][j] = PCW'(r[3][j]) - PCW'(r[0][j]);
      pl_next[2][j] = PCW'(r[3][j]) + PCW'(r[1][j]);
      pl_next[3][j] = PCW'(r[3][j]) - PCW'(r[1][j]);
      pl_next[4][j] = PCW'(r[2][j]);
      pl_next[5][j] = PCW'(r[3][j]) - PCW'(r[2][j]);
    end
    for (int j = 0; j < 3; j++) begin
      wmin[j] = pop_data[j*COORD_WIDTH +: COORD_WIDTH];
      wmax[j] = pop_data[(j+3)*COORD_WIDTH +: COORD_WIDTH];
    end
    for (int p = 0; p < PLANES; p++) begin
      for (int j = 0; j < 3; j++) begin
        prod_next[p][j] = PPW'(pl[p][j]) * PPW'(pl[p][j][PCW-1] ? wmin[j] : wmax[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    pl <= pl_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b1_valid  <= pop_valid;
      out_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= prod_next;
      b1_box <= pop_data;
      for (int p = 0; p < PLANES; p++) begin
        ct[p] <= $signed({pl[p][3], {COORD_FRAC{1'b0}}});
      end
    end
  end

  always_comb begin
    all_pass = 1'b1;
    for (int p = 0; p < PLANES; p++) begin
      d = DW'(prod[p][0]) + DW'(prod[p][1]) + DW'(prod[p][2]) + DW'(ct[p]);
      if (d[DW-1]) begin
        all_pass = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      visible     <= all_pass;
      world_min_x <= b1_box[0*COORD_WIDTH +: COORD_WIDTH];
      world_min_y <= b1_box[1*COORD_WIDTH +: COORD_WIDTH];
      world_min_z <= b1_box[2*COORD_WIDTH +: COORD_WIDTH];
      world_max_x <= b1_box[3*COORD_WIDTH +: COORD_WIDTH];
      world_max_y <= b1_box[4*COORD_WIDTH +: COORD_WIDTH];
      world_max_z <= b1_box[5*COORD_WIDTH +: COORD_WIDTH];
    end
  end

endmodule

// ===== rtl/core/aabb_frustum_cull_core.sv =====
// Box culling core. Load items (func 0) write one row of the affine world
// matrix in the accept cycle and return nothing; test items (func 1) return
// one result: the local box mapped to the enclosing world box, rounded
// outward and saturated, plus the visible flag from the six frustum planes
// built from the view-projection rows. One item is accepted per cycle while
// in_stall is low. A test result goes through these steps in order: the
// accept edge loads the nine-lane transform multipliers, the world-box sums
// are written into a four-entry queue, the eighteen plane multipliers are
// loaded from the queue head and the plane sums are written into the output
// register. The queue lets the transform side keep taking items while the
// output is stalled, until it fills. Write the view-projection rows only
// while the core is idle.
module aabb_frustum_cull_core import acull_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int COEF_WIDTH  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [WORD_W-1:0]      cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   func,
  input  logic [1:0]             row_index,
  input  logic [WORD_W-1:0]      row_word,
  input  logic [COORD_WIDTH-1:0] box_min_x,
  input  logic [COORD_WIDTH-1:0] box_min_y,
  input  logic [COORD_WIDTH-1:0] box_min_z,
  input  logic [COORD_WIDTH-1:0] box_max_x,
  input  logic [COORD_WIDTH-1:0] box_max_y,
  input  logic [COORD_WIDTH-1:0] box_max_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   visible,
  output logic [COORD_WIDTH-1:0] world_min_x,
  output logic [COORD_WIDTH-1:0] world_min_y,
  output logic [COORD_WIDTH-1:0] world_min_z,
  output logic [COORD_WIDTH-1:0] world_max_x,
  output logic [COORD_WIDTH-1:0] world_max_y,
  output logic [COORD_WIDTH-1:0] world_max_z
);

  localparam int BOX_W = 6 * COORD_WIDTH;

  logic [WORD_W-1:0] vp_row [VP_ROWS];
  q_status_t         q_status;
  logic              push;
  logic [BOX_W-1:0]  push_data;
  logic              pop;
  logic              pop_valid;
  logic [BOX_W-1:0]  pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VP_ROWS; i++) begin
        vp_row[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      vp_row[cfg_index] <= cfg_data;
    end
  end

  acull_front #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_stall, .func, .row_index, .row_word,
    .box_min_x, .box_min_y, .box_min_z, .box_max_x, .box_max_y, .box_max_z,
    .q_status, .push, .push_data
  );

  acull_queue #(.DATA_W(BOX_W)) u_queue (
    .clk, .rst, .push, .push_data, .pop, .pop_valid, .pop_data, .q_status
  );

  acull_back #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_back (
    .clk, .rst, .vp_row, .pop_valid, .pop_data, .pop, .out_valid, .out_stall,
    .visible, .world_min_x, .world_min_y, .world_min_z,
    .world_max_x, .world_max_y, .world_max_z
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full && !(pop && pop_valid)))
    else $error("queue overflow");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && func_t'(func) == FUNC_LOAD) |=> !push)
    else $error("load item pushed a result");

  a_box_x: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(world_min_x) <= $signed(world_max_x))
    else $error("world box x inverted");

  a_box_z: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(world_min_z) <= $signed(world_max_z))
    else $error("world box z inverted");

endmodule
